### hw/rtl/bba_pkg.sv
// Shared types, sizes and codes of the bitmap block allocator.
package bba_pkg;

	localparam int MAX_SIDE  = 64;
	localparam int MAX_FILES = 64;

	localparam int NBLOCKS   = MAX_SIDE * MAX_SIDE;
	localparam int CFG_W     = 7;
	localparam int SLOT_W    = 6;
	localparam int LEN_W     = 13;
	localparam int START_W   = 12;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
	localparam int BLK_W     = $clog2(NBLOCKS + 1);
	localparam int IDX_W     = $clog2(NBLOCKS);
	localparam int END_W     = ((BLK_W > LEN_W) ? BLK_W : LEN_W) + 1;
	localparam int SLOT_AW   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

	localparam int BM_WORD_W = (NBLOCKS < 64) ? NBLOCKS : 64;
	localparam int BIT_W     = $clog2(BM_WORD_W);
	localparam int NWORDS    = (NBLOCKS + BM_WORD_W - 1) / BM_WORD_W;
	localparam int WORD_AW   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(64);
	localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS    = 1'b0,
		REG_COLUMNS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_USED      = 3'd2,
		ST_NO_SPACE  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] file_slot;
		logic [LEN_W-1:0]  request_length;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  start_block;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] start;
		logic [LEN_W-1:0] length;
	} slot_ent_t;

	// Handshake between the port logic and the engine.
	typedef struct packed {
		logic start;
		logic take;
	} eng_ctl_t;

	function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

endpackage

### hw/rtl/bitmap_block_allocator_unit.sv
// Top level of the bitmap block allocator: ports, configuration registers and result register.
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+---------------------------------
//  req     | req_valid, req_ready, req      | in        | command, file_slot, request_length
//  rsp     | rsp_valid, rsp_ready, rsp      | out       | status, start_block
//  cfg     | cfg_valid, cfg_ready, cfg_index| in        | cfg_data (rows, columns)
//
// An allocate scans the bitmap one block per cycle, pausing to fetch each 64-block word
// from the bitmap RAM, then marks the run one block per cycle, pausing to fetch and write
// back each word touched. A free reads the file table entry, then clears its run the same way.
// Error answers go straight to the result without touching the bitmap.
// After reset the bitmap reads as free at once: per-word valid flops, no clearing pass.
// A new request is taken once the engine is idle; a waiting result does not block it.
module bitmap_block_allocator_unit
	import bba_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] columns_q;
	logic [BLK_W-1:0] total_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	eng_ctl_t         ctl;
	logic             eng_idle;
	logic             eng_done;
	rsp_t             eng_result;

	assign cfg_ready = 1'b1;
	assign req_ready = eng_idle;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign ctl.start = req_valid && eng_idle;
	assign ctl.take  = eng_done && (!rsp_valid_q || rsp_ready);

	bba_engine u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.req   (req),
		.total (total_q),
		.idle  (eng_idle),
		.done  (eng_done),
		.result(eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= ROWS_RESET;
			columns_q   <= COLUMNS_RESET;
			total_q     <= BLK_W'(NBLOCKS);
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROWS:    rows_q    <= cfg_data;
					REG_COLUMNS: columns_q <= cfg_data;
					default:     rows_q    <= rows_q;
				endcase
			end
			total_q <= BLK_W'(side_clamp(rows_q)) * BLK_W'(side_clamp(columns_q));
			if (ctl.take) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= eng_result;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/bba_engine.sv
// Sequencer that scans and updates the block bitmap, one bit per cycle between word accesses, and the file table.
module bba_engine
	import bba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  eng_ctl_t         ctl,
	input  req_t             req,
	input  logic [BLK_W-1:0] total,
	output logic             idle,
	output logic             done,
	output rsp_t             result
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SLOT_RD,
		S_SLOT_LD,
		S_RD,
		S_LD,
		S_SCAN,
		S_MARK,
		S_WR,
		S_FIN,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic                   mode_q;
	logic                   marking_q;
	logic                   last_q;
	logic [SLOT_AW-1:0]     slot_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       run_q;
	logic [BLK_W-1:0]       i_q;
	logic [END_W-1:0]       end_q;
	logic [IDX_W-1:0]       start_q;
	logic [BM_WORD_W-1:0]   word_q;
	logic [WORD_AW-1:0]     wa_q;
	logic [NWORDS-1:0]      rv_q;
	logic [MAX_FILES-1:0]   slot_valid_q;
	rsp_t                   result_q;

	logic [SLOT_AW-1:0]     req_slot;
	logic                   req_in_range;
	logic [WORD_AW-1:0]     word_idx;
	logic [BIT_W-1:0]       bit_idx;
	logic [BM_WORD_W-1:0]   bm_rdata;
	slot_ent_t              slot_rdata;
	slot_ent_t              slot_wdata;
	logic                   slot_we;
	logic [LEN_W-1:0]       run_nx;
	logic [BLK_W-1:0]       i_nx;
	logic [BLK_W-1:0]       found_start;

	assign req_slot     = SLOT_AW'(req.file_slot);
	assign req_in_range = 32'(req.file_slot) < MAX_FILES;
	assign word_idx     = WORD_AW'(i_q >> BIT_W);
	assign bit_idx      = i_q[BIT_W-1:0];
	assign run_nx       = run_q + LEN_W'(1);
	assign i_nx         = i_q + BLK_W'(1);
	assign found_start  = i_nx - BLK_W'(len_q);

	assign slot_we           = (state_q == S_FIN) && (mode_q == CMD_ALLOC);
	assign slot_wdata.start  = start_q;
	assign slot_wdata.length = len_q;

	assign idle   = (state_q == S_IDLE);
	assign done   = (state_q == S_DONE);
	assign result = result_q;

	bba_ram #(
		.WIDTH(BM_WORD_W),
		.DEPTH(NWORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (state_q == S_WR),
		.waddr(wa_q),
		.wdata(word_q),
		.raddr(word_idx),
		.rdata(bm_rdata)
	);

	bba_ram #(
		.WIDTH($bits(slot_ent_t)),
		.DEPTH(MAX_FILES)
	) u_slots (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_q),
		.wdata(slot_wdata),
		.raddr(slot_q),
		.rdata(slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= CMD_ALLOC;
			marking_q    <= 1'b0;
			last_q       <= 1'b0;
			slot_q       <= '0;
			len_q        <= '0;
			run_q        <= '0;
			i_q          <= '0;
			end_q        <= '0;
			start_q      <= '0;
			word_q       <= '0;
			wa_q         <= '0;
			rv_q         <= '0;
			slot_valid_q <= '0;
			result_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						mode_q    <= req.command;
						slot_q    <= req_slot;
						len_q     <= req.request_length;
						marking_q <= 1'b0;
						run_q     <= '0;
						i_q       <= '0;
						start_q   <= '0;
						result_q  <= '0;
						if (req.command == CMD_ALLOC) begin
							if (req.request_length == '0) begin
								result_q.status <= ST_ZERO;
								state_q         <= S_DONE;
							end else if (!req_in_range || slot_valid_q[req_slot]) begin
								result_q.status <= ST_USED;
								state_q         <= S_DONE;
							end else begin
								state_q <= S_RD;
							end
						end else begin
							if (!req_in_range || !slot_valid_q[req_slot]) begin
								result_q.status <= ST_NOT_FOUND;
								state_q         <= S_DONE;
							end else begin
								state_q <= S_SLOT_RD;
							end
						end
					end
				end
				S_SLOT_RD: begin
					state_q <= S_SLOT_LD;
				end
				S_SLOT_LD: begin
					start_q   <= slot_rdata.start;
					i_q       <= BLK_W'(slot_rdata.start);
					end_q     <= END_W'(slot_rdata.start) + END_W'(slot_rdata.length);
					marking_q <= 1'b1;
					state_q   <= S_RD;
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					// A word never written since reset still reads as all free.
					word_q  <= rv_q[word_idx] ? bm_rdata : '0;
					wa_q    <= word_idx;
					state_q <= marking_q ? S_MARK : S_SCAN;
				end
				S_SCAN: begin
					if (i_q >= total) begin
						result_q.status <= ST_NO_SPACE;
						state_q         <= S_DONE;
					end else if (!word_q[bit_idx] && (run_nx == len_q)) begin
						start_q   <= IDX_W'(found_start);
						i_q       <= found_start;
						end_q     <= END_W'(found_start) + END_W'(len_q);
						marking_q <= 1'b1;
						state_q   <= S_RD;
					end else begin
						run_q <= word_q[bit_idx] ? '0 : run_nx;
						i_q   <= i_nx;
						if (bit_idx == BIT_W'(BM_WORD_W - 1)) begin
							state_q <= S_RD;
						end
					end
				end
				S_MARK: begin
					word_q[bit_idx] <= (mode_q == CMD_ALLOC);
					i_q             <= i_nx;
					last_q          <= (END_W'(i_nx) == end_q) || (i_nx == BLK_W'(NBLOCKS));
					if ((END_W'(i_nx) == end_q) || (i_nx == BLK_W'(NBLOCKS)) ||
					    (bit_idx == BIT_W'(BM_WORD_W - 1))) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					rv_q[wa_q] <= 1'b1;
					state_q    <= last_q ? S_FIN : S_RD;
				end
				S_FIN: begin
					slot_valid_q[slot_q] <= (mode_q == CMD_ALLOC);
					result_q.status      <= ST_OK;
					result_q.start_block <= START_W'(start_q);
					state_q              <= S_DONE;
				end
				S_DONE: begin
					if (ctl.take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### test/bitmap_block_allocator_unit_tb.sv
// Self-checking testbench for the bitmap block allocator: directed table, then random phases.
module bitmap_block_allocator_unit_tb;
	import bba_pkg::*;

	typedef struct {
		cmd_t               cmd;
		logic [SLOT_W-1:0]  slot;
		logic [LEN_W-1:0]   len;
		bit                 known;
		status_t            st;
		logic [START_W-1:0] first;
	} dir_row_t;

	localparam int N_DIRECTED = 24;
	localparam int HOLD_CYCLES = 3000;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Shadow of the allocator state.
	bit                 blk_used [NBLOCKS];
	bit                 slot_busy [MAX_FILES];
	int unsigned        slot_first [MAX_FILES];
	int unsigned        slot_len [MAX_FILES];
	logic [CFG_W-1:0]   rows_reg = ROWS_RESET;
	logic [CFG_W-1:0]   cols_reg = COLUMNS_RESET;

	rsp_t     answers [$];
	int       mismatches = 0;
	bit       hold_req = 1'b0;
	bit       steady = 1'b0;
	dir_row_t directed_rows [N_DIRECTED];

	bitmap_block_allocator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned side_of(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return 1;
		end else if (int'(v) > MAX_SIDE) begin
			return MAX_SIDE;
		end
		return int'(v);
	endfunction

	// First-fit allocation and release on the shadow state.
	function automatic rsp_t serve_request(input req_t r);
		rsp_t        a;
		int unsigned total;
		int unsigned run;
		int unsigned i;
		int unsigned first;
		int unsigned len;
		bit          found;
		a.status = ST_OK;
		a.start_block = '0;
		len = r.request_length;
		if (r.command == CMD_ALLOC) begin
			if (len == 0) begin
				a.status = ST_ZERO;
			end else if (slot_busy[r.file_slot]) begin
				a.status = ST_USED;
			end else begin
				total = side_of(rows_reg) * side_of(cols_reg);
				run = 0;
				first = 0;
				found = 1'b0;
				for (i = 0; i < total && !found; i++) begin
					if (blk_used[i]) begin
						run = 0;
					end else begin
						run++;
						if (run == len) begin
							first = i + 1 - len;
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					a.status = ST_NO_SPACE;
				end else begin
					for (i = first; i < first + len; i++) blk_used[i] = 1'b1;
					slot_busy[r.file_slot] = 1'b1;
					slot_first[r.file_slot] = first;
					slot_len[r.file_slot] = len;
					a.start_block = START_W'(first);
				end
			end
		end else begin
			if (!slot_busy[r.file_slot]) begin
				a.status = ST_NOT_FOUND;
			end else begin
				first = slot_first[r.file_slot];
				// The whole recorded run is released even if the bitmap shrank since.
				for (i = first; i < first + slot_len[r.file_slot]; i++) begin
					if (i < NBLOCKS) blk_used[i] = 1'b0;
				end
				slot_busy[r.file_slot] = 1'b0;
				a.start_block = START_W'(first);
			end
		end
		return a;
	endfunction

	function automatic int gap_pick();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// Mostly well-formed requests: allocate into a free slot, free an occupied one.
	function automatic req_t make_request();
		req_t        r;
		int unsigned total;
		int unsigned pick;
		int unsigned s;
		int          k;
		total = side_of(rows_reg) * side_of(cols_reg);
		pick = $urandom_range(0, 99);
		r.command = CMD_ALLOC;
		s = $urandom_range(0, MAX_FILES - 1);
		r.request_length = LEN_W'($urandom_range(0, 4096));
		if (pick < 45) begin
			for (k = 0; k < MAX_FILES && slot_busy[s]; k++) s = (s + 1) % MAX_FILES;
			if ($urandom_range(0, 9) == 0) begin
				r.request_length = LEN_W'($urandom_range(total, 4096));
			end else begin
				r.request_length = LEN_W'($urandom_range(1, (total > 3) ? total / 3 : 1));
			end
		end else if (pick < 80) begin
			r.command = CMD_FREE;
			for (k = 0; k < MAX_FILES && !slot_busy[s]; k++) s = (s + 1) % MAX_FILES;
		end else begin
			r.command = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0) r.request_length = '0;
		end
		r.file_slot = SLOT_W'(s);
		return r;
	endfunction

	task automatic send_item(input req_t r, input bit known, input rsp_t typed);
		int   gap;
		rsp_t p;
		gap = gap_pick();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		p = serve_request(r);
		if (known) p = typed;
		answers.push_back(p);
	endtask

	// Both registers in one burst so that valid stays high between the two transactions.
	task automatic write_shape(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		rows_reg = r;
		cfg_index <= REG_COLUMNS;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		cols_reg = c;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
			input int count, input bit squeeze, input bit no_idle);
		int   n;
		rsp_t none;
		none = '0;
		write_shape(r, c);
		steady = no_idle;
		if (squeeze) hold_req = 1'b1;
		for (n = 0; n < count; n++) send_item(make_request(), 1'b0, none);
		drain();
		steady = 1'b0;
	endtask

	task automatic check_answer(input rsp_t got);
		rsp_t want;
		if (answers.size() == 0) begin
			if (mismatches < 10) $display("unexpected result: status %0d start %0d",
				got.status, got.start_block);
			mismatches++;
		end else begin
			want = answers.pop_front();
			if (got.status !== want.status || got.start_block !== want.start_block) begin
				if (mismatches < 10) begin
					$display("mismatch: expected status %0d start %0d, got status %0d start %0d",
						want.status, want.start_block, got.status, got.start_block);
				end
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) check_answer(rsp);
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		int hold_count;
		rsp_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				rsp_ready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				hold_req = 1'b0;
			end else if (steady) begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				rsp_ready <= 1'b0;
				hold_count = gap_pick();
				repeat ((hold_count == 0) ? 1 : hold_count) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		int   n;
		req_t r;
		rsp_t typed;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ROWS;
		cfg_data <= '0;
		directed_rows = '{
			'{CMD_ALLOC, 6'd0,  13'd0,    1'b1, ST_ZERO,      12'd0},
			'{CMD_FREE,  6'd5,  13'd0,    1'b1, ST_NOT_FOUND, 12'd0},
			'{CMD_FREE,  6'd63, 13'd4096, 1'b1, ST_NOT_FOUND, 12'd0},
			'{CMD_ALLOC, 6'd0,  13'd4096, 1'b1, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd1,  13'd1,    1'b1, ST_NO_SPACE,  12'd0},
			// Zero length wins over an occupied slot.
			'{CMD_ALLOC, 6'd0,  13'd0,    1'b1, ST_ZERO,      12'd0},
			'{CMD_ALLOC, 6'd0,  13'd5,    1'b1, ST_USED,      12'd0},
			'{CMD_FREE,  6'd0,  13'd0,    1'b1, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd63, 13'd1,    1'b1, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd0,  13'd10,   1'b1, ST_OK,        12'd1},
			'{CMD_ALLOC, 6'd1,  13'd1,    1'b1, ST_OK,        12'd11},
			'{CMD_FREE,  6'd0,  13'd0,    1'b1, ST_OK,        12'd1},
			'{CMD_ALLOC, 6'd2,  13'd4,    1'b1, ST_OK,        12'd1},
			'{CMD_ALLOC, 6'd3,  13'd7,    1'b0, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd4,  13'd6,    1'b0, ST_OK,        12'd0},
			'{CMD_FREE,  6'd63, 13'd8,    1'b1, ST_OK,        12'd0},
			'{CMD_FREE,  6'd63, 13'd0,    1'b1, ST_NOT_FOUND, 12'd0},
			'{CMD_ALLOC, 6'd5,  13'd4096, 1'b1, ST_NO_SPACE,  12'd0},
			'{CMD_ALLOC, 6'd42, 13'd4077, 1'b0, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd6,  13'd1,    1'b0, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd7,  13'd1,    1'b0, ST_OK,        12'd0},
			'{CMD_FREE,  6'd42, 13'd0,    1'b0, ST_OK,        12'd0},
			'{CMD_ALLOC, 6'd21, 13'd4095, 1'b0, ST_OK,        12'd0},
			'{CMD_FREE,  6'd3,  13'd0,    1'b0, ST_OK,        12'd0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++) begin
			r.command = directed_rows[n].cmd;
			r.file_slot = directed_rows[n].slot;
			r.request_length = directed_rows[n].len;
			typed.status = directed_rows[n].st;
			typed.start_block = directed_rows[n].first;
			send_item(r, directed_rows[n].known, typed);
		end
		drain();

		// The bitmap shrinks under runs left over from the directed part.
		run_phase(7'd8,   7'd8,   14, 1'b0, 1'b0);
		run_phase(7'd1,   7'd1,   10, 1'b0, 1'b0);
		run_phase(7'd0,   7'd127, 14, 1'b0, 1'b1);
		run_phase(7'd127, 7'd0,   14, 1'b0, 1'b0);
		run_phase(7'd3,   7'd5,   16, 1'b1, 1'b0);
		run_phase(7'd64,  7'd64,  14, 1'b0, 1'b0);
		run_phase(7'd2,   7'd64,  14, 1'b0, 1'b0);
		run_phase(7'd16,  7'd16,  16, 1'b0, 1'b0);
		run_phase(7'd100, 7'd2,   14, 1'b0, 1'b0);
		run_phase(7'd5,   7'd9,   14, 1'b0, 1'b0);

		repeat (20) @(posedge clk);
		if (mismatches == 0 && answers.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
